### rtl/core/erm_pkg.sv
// erm_pkg: beat types, CORDIC tables and fixed-point helpers for the
// euler angle to rotation matrix pipeline. No dependencies.
package erm_pkg;

    // cordic datapath widths: x/y in Q30 with headroom, angle in 2^32 per turn
    localparam int XW        = 33;
    localparam int ZW        = 34;
    localparam int MIN_STEPS = 8;
    localparam int MAX_STEPS = 24;
    localparam int OW        = 35;

    typedef struct packed {
        logic [15:0] angle_x;
        logic [15:0] angle_y;
        logic [15:0] angle_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } out_t;

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [0:MAX_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // cordic gain in Q30 for 8..24 steps
    localparam logic [31:0] GAIN_TAB [0:MAX_STEPS-MIN_STEPS] = '{
        32'd652039508, 32'd652034533, 32'd652033289, 32'd652032978,
        32'd652032901, 32'd652032881, 32'd652032876, 32'd652032875,
        32'd652032875, 32'd652032875, 32'd652032875, 32'd652032875,
        32'd652032875, 32'd652032875, 32'd652032875, 32'd652032875,
        32'd652032875
    };

    // Q30 by Q30 product back to Q30, round half up
    function automatic logic signed [XW-1:0] mul30(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
        logic signed [2*XW-1:0] p;
        p = a * b + (66'sd1 <<< 29);
        return p[30+XW-1:30];
    endfunction

endpackage

### rtl/core/euler_angles_to_rotation_matrix_top.sv
// euler_angles_to_rotation_matrix_top: pipelined R = Rx*Ry*Rz from three angles.
// Depends on erm_pkg for beat types, cordic tables and mul30.

// Takes one angle triple per clock and returns the nine Q2.14 entries of the
// 3x3 rotation matrix. Each triple passes through CORDIC_STEPS+5 register
// stages: one load stage, one cordic stage per micro-rotation (three lanes
// side by side), a quadrant fixup stage, two multiply stages and a
// rounding/saturation output register. A step count outside 8..24 is clamped
// to that range. Throughput is one beat per cycle; when the output beat is
// not taken the whole pipeline holds in place and in_ready drops.
module euler_angles_to_rotation_matrix_top #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  erm_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output erm_pkg::out_t  out_data
);
    import erm_pkg::*;

    localparam int N  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                        ((CORDIC_STEPS < MIN_STEPS) ? MIN_STEPS : CORDIC_STEPS);
    localparam int SH = 30 - FRAC_BITS;

    // Q30 sum down to output format with saturation
    function automatic logic signed [15:0] to_out(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] r;
        r = (v + (OW'(1) <<< (SH - 1))) >>> SH;
        if (r > OW'(32767))
            return 16'sh7FFF;
        else if (r < -OW'(32768))
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

    logic advance;

    // cordic pipeline, lanes 0..2 = x, y, z angles
    logic                 cv_reg [0:N];
    logic signed [XW-1:0] x_reg  [0:N][0:2];
    logic signed [XW-1:0] y_reg  [0:N][0:2];
    logic signed [ZW-1:0] z_reg  [0:N][0:2];
    logic [1:0]           q_reg  [0:N][0:2];
    logic signed [XW-1:0] x_next [0:N][0:2];
    logic signed [XW-1:0] y_next [0:N][0:2];
    logic signed [ZW-1:0] z_next [0:N][0:2];
    logic [1:0]           q_next [0:N][0:2];

    logic                 qv_reg;
    logic signed [XW-1:0] c_reg [0:2];
    logic signed [XW-1:0] s_reg [0:2];
    logic signed [XW-1:0] c_next [0:2];
    logic signed [XW-1:0] s_next [0:2];

    logic                 m1v_reg;
    logic signed [XW-1:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg;
    logic signed [XW-1:0] cxcz_reg, sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    logic signed [XW-1:0] sy1_reg, cz1_reg, sz1_reg;

    logic                 m2v_reg;
    logic signed [XW-1:0] a10_reg, a11_reg, a20_reg, a21_reg;
    logic signed [XW-1:0] cycz2_reg, cysz2_reg, cxsz2_reg, cxcz2_reg, sxcy2_reg;
    logic signed [XW-1:0] sxsz2_reg, sxcz2_reg, cxcy2_reg, sy2_reg;

    logic                 out_valid_reg;
    out_t                 out_reg, out_next;
    logic [15:0]          ang [0:2];

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign ang[0]   = in_data.angle_x;
    assign ang[1]   = in_data.angle_y;
    assign ang[2]   = in_data.angle_z;

    // load: quadrant split and cordic seed, then one micro-rotation per stage
    always_comb
    begin
        logic [31:0] a32;
        logic [31:0] d;
        logic [ANGLE_BITS-1:0] a_m;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        for (int l = 0; l < 3; l++)
        begin
            a_m = ANGLE_BITS'({{(32-16){1'b0}}, ang[l]});
            a32 = {a_m, {(32-ANGLE_BITS){1'b0}}};
            q_next[0][l] = 2'((a32 + 32'h20000000) >> 30);
            d = a32 - {q_next[0][l], 30'd0};
            z_next[0][l] = ZW'($signed(d));
            x_next[0][l] = XW'(GAIN_TAB[N-MIN_STEPS]);
            y_next[0][l] = '0;
        end
        for (int s = 0; s < N; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                xs = x_reg[s][l] >>> s;
                ys = y_reg[s][l] >>> s;
                q_next[s+1][l] = q_reg[s][l];
                if (!z_reg[s][l][ZW-1])
                begin
                    x_next[s+1][l] = x_reg[s][l] - ys;
                    y_next[s+1][l] = y_reg[s][l] + xs;
                    z_next[s+1][l] = z_reg[s][l] - ZW'(ATAN_TAB[s]);
                end
                else
                begin
                    x_next[s+1][l] = x_reg[s][l] + ys;
                    y_next[s+1][l] = y_reg[s][l] - xs;
                    z_next[s+1][l] = z_reg[s][l] + ZW'(ATAN_TAB[s]);
                end
            end
        end
    end

    // quadrant fixup by swap and negate
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            unique case (q_reg[N][l])
                2'd0:
                begin
                    c_next[l] = x_reg[N][l];
                    s_next[l] = y_reg[N][l];
                end
                2'd1:
                begin
                    c_next[l] = -y_reg[N][l];
                    s_next[l] = x_reg[N][l];
                end
                2'd2:
                begin
                    c_next[l] = -x_reg[N][l];
                    s_next[l] = -y_reg[N][l];
                end
                default:
                begin
                    c_next[l] = y_reg[N][l];
                    s_next[l] = -x_reg[N][l];
                end
            endcase
        end
    end

    // sums, rounding and saturation
    always_comb
    begin
        out_next.r00 = to_out(OW'(cycz2_reg));
        out_next.r01 = to_out(-OW'(cysz2_reg));
        out_next.r02 = to_out(-OW'(sy2_reg));
        out_next.r10 = to_out(OW'(cxsz2_reg) - OW'(a10_reg));
        out_next.r11 = to_out(OW'(a11_reg) + OW'(cxcz2_reg));
        out_next.r12 = to_out(-OW'(sxcy2_reg));
        out_next.r20 = to_out(OW'(a20_reg) + OW'(sxsz2_reg));
        out_next.r21 = to_out(OW'(sxcz2_reg) - OW'(a21_reg));
        out_next.r22 = to_out(OW'(cxcy2_reg));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N; s++)
                cv_reg[s] <= 1'b0;
            qv_reg        <= 1'b0;
            m1v_reg       <= 1'b0;
            m2v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cv_reg[0] <= in_valid;
            for (int s = 0; s < N; s++)
                cv_reg[s+1] <= cv_reg[s];
            qv_reg        <= cv_reg[N];
            m1v_reg       <= qv_reg;
            m2v_reg       <= m1v_reg;
            out_valid_reg <= m2v_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= N; s++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    x_reg[s][l] <= x_next[s][l];
                    y_reg[s][l] <= y_next[s][l];
                    z_reg[s][l] <= z_next[s][l];
                    q_reg[s][l] <= q_next[s][l];
                end
            end
            for (int l = 0; l < 3; l++)
            begin
                c_reg[l] <= c_next[l];
                s_reg[l] <= s_next[l];
            end
            // first products
            sxsy_reg <= mul30(s_reg[0], s_reg[1]);
            cxsy_reg <= mul30(c_reg[0], s_reg[1]);
            cycz_reg <= mul30(c_reg[1], c_reg[2]);
            cysz_reg <= mul30(c_reg[1], s_reg[2]);
            cxsz_reg <= mul30(c_reg[0], s_reg[2]);
            cxcz_reg <= mul30(c_reg[0], c_reg[2]);
            sxcy_reg <= mul30(s_reg[0], c_reg[1]);
            sxsz_reg <= mul30(s_reg[0], s_reg[2]);
            sxcz_reg <= mul30(s_reg[0], c_reg[2]);
            cxcy_reg <= mul30(c_reg[0], c_reg[1]);
            sy1_reg  <= s_reg[1];
            cz1_reg  <= c_reg[2];
            sz1_reg  <= s_reg[2];
            // second products
            a10_reg   <= mul30(sxsy_reg, cz1_reg);
            a11_reg   <= mul30(sxsy_reg, sz1_reg);
            a20_reg   <= mul30(cxsy_reg, cz1_reg);
            a21_reg   <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcy2_reg <= sxcy_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // accepted beat lands in the first stage
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> cv_reg[0])
        else $error("accepted beat not loaded");

    // a held pipeline keeps its last cordic stage and its second multiply stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cv_reg[N]) && $stable(m2v_reg))
        else $error("pipeline moved while stalled");

    // output valid only comes from the last multiply stage
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(m2v_reg))
        else $error("output valid without source");

endmodule
